### design/ilist_pkg.sv
// Shared types, codes and sizes for the indexed list block.
package ilist_pkg;

    // Store size and field widths
    localparam int CAPACITY = 1024;
    localparam int W_IDX    = $clog2(CAPACITY + 1);   // holds 0..CAPACITY
    localparam int W_ADDR   = $clog2(CAPACITY);       // store address
    localparam int W_DATA   = 32;

    // Request codes
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_DELETE = 2'd2,
        OP_INSERT = 2'd3
    } t_op;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ,
        S_SHIFT,
        S_MOVE,
        S_RESP
    } t_state;

    // Store read address source
    typedef enum logic [1:0] {
        RD_POS,
        RD_PTR_INC,
        RD_PTR_DEC
    } t_rd_sel;

    // Store write source
    typedef enum logic {
        WR_POS_VAL,
        WR_PTR_RDATA
    } t_wr_sel;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_req;
        t_rd_sel rd_sel;
        logic    mem_we;
        t_wr_sel wr_sel;
        logic    ptr_from_pos;
        logic    ptr_from_count;
        logic    ptr_inc;
        logic    ptr_dec;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_load;
        t_status res_status;
        logic    res_take_read;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_op  op;
        logic pos_ge_count;
        logic pos_gt_count;
        logic full;
        logic ptr_lt_count;
        logic ptr_gt_pos;
    } t_stat;

endpackage

### design/ilist_dp.sv
// Datapath: request registers, entry store, shift pointer, count and result registers.
module ilist_dp import ilist_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_stat,
    input  logic [1:0]               i_operation,
    input  logic [W_IDX-1:0]         i_position,
    input  logic signed [W_DATA-1:0] i_new_value,
    output logic [1:0]               o_status,
    output logic signed [W_DATA-1:0] o_read_value,
    output logic [W_IDX-1:0]         o_entry_count
);

    logic [W_DATA-1:0] r_mem [CAPACITY];

    t_op               r_op;
    logic [W_IDX-1:0]  r_pos;
    logic [W_DATA-1:0] r_val;
    logic [W_IDX-1:0]  r_ptr;
    logic [W_IDX-1:0]  r_count;
    logic [W_IDX-1:0]  n_count;
    logic [W_DATA-1:0] r_rdata;
    t_status           r_status;
    logic [W_DATA-1:0] r_read_value;

    logic [W_IDX-1:0]  w_ptr_inc;
    logic [W_IDX-1:0]  w_ptr_dec;
    logic [W_ADDR-1:0] w_rd_addr;
    logic [W_ADDR-1:0] w_wr_addr;
    logic [W_DATA-1:0] w_wr_data;

    assign w_ptr_inc = r_ptr + W_IDX'(1);
    assign w_ptr_dec = r_ptr - W_IDX'(1);

    // Read address select
    always_comb begin
        case (i_cmd.rd_sel)
            RD_POS:     w_rd_addr = r_pos[W_ADDR-1:0];
            RD_PTR_INC: w_rd_addr = w_ptr_inc[W_ADDR-1:0];
            RD_PTR_DEC: w_rd_addr = w_ptr_dec[W_ADDR-1:0];
            default:    w_rd_addr = r_pos[W_ADDR-1:0];
        endcase
    end

    // Write address and data select
    always_comb begin
        case (i_cmd.wr_sel)
            WR_POS_VAL: begin
                w_wr_addr = r_pos[W_ADDR-1:0];
                w_wr_data = r_val;
            end
            WR_PTR_RDATA: begin
                w_wr_addr = r_ptr[W_ADDR-1:0];
                w_wr_data = r_rdata;
            end
            default: begin
                w_wr_addr = r_pos[W_ADDR-1:0];
                w_wr_data = r_val;
            end
        endcase
    end

    // Entry store: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op  <= t_op'(i_operation);
            r_pos <= i_position;
            r_val <= i_new_value;
        end
    end

    // Shift pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.ptr_from_pos) begin
            r_ptr <= r_pos;
        end else if (i_cmd.ptr_from_count) begin
            r_ptr <= r_count;
        end else if (i_cmd.ptr_inc) begin
            r_ptr <= w_ptr_inc;
        end else if (i_cmd.ptr_dec) begin
            r_ptr <= w_ptr_dec;
        end
    end

    // Entry count
    always_comb begin
        n_count = r_count;
        if (i_cmd.cnt_inc) begin
            n_count = r_count + W_IDX'(1);
        end else if (i_cmd.cnt_dec) begin
            n_count = r_count - W_IDX'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status     <= i_cmd.res_status;
            r_read_value <= i_cmd.res_take_read ? r_rdata : '0;
        end
    end

    // Status to controller
    assign o_stat.op           = r_op;
    assign o_stat.pos_ge_count = (r_pos >= r_count);
    assign o_stat.pos_gt_count = (r_pos > r_count);
    assign o_stat.full         = (r_count == W_IDX'(CAPACITY));
    assign o_stat.ptr_lt_count = (r_ptr < r_count);
    assign o_stat.ptr_gt_pos   = (r_ptr > r_pos);

    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_entry_count = r_count;

endmodule

### design/ilist_ctrl.sv
// Controller: sequences request decode, range checks, shift loops and the result handshake.
module ilist_ctrl import ilist_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_INSERT) begin
                    if (i_stat.pos_gt_count) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_RANGE;
                        n_state          = S_RESP;
                    end else if (i_stat.full) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.ptr_from_count = 1'b1;
                        n_state              = S_SHIFT;
                    end
                end else if (i_stat.pos_ge_count) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_RANGE;
                    n_state          = S_RESP;
                end else begin
                    case (i_stat.op)
                        OP_READ: begin
                            o_cmd.rd_sel = RD_POS;
                            n_state      = S_READ;
                        end
                        OP_UPDATE: begin
                            o_cmd.mem_we     = 1'b1;
                            o_cmd.wr_sel     = WR_POS_VAL;
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = ST_DONE;
                            n_state          = S_RESP;
                        end
                        OP_DELETE: begin
                            o_cmd.cnt_dec      = 1'b1;
                            o_cmd.ptr_from_pos = 1'b1;
                            n_state            = S_SHIFT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ: begin
                o_cmd.res_load      = 1'b1;
                o_cmd.res_status    = ST_DONE;
                o_cmd.res_take_read = 1'b1;
                n_state             = S_RESP;
            end
            // Loop test: delete pulls entries down, insert pushes them up
            S_SHIFT: begin
                if (i_stat.op == OP_DELETE) begin
                    if (i_stat.ptr_lt_count) begin
                        o_cmd.rd_sel = RD_PTR_INC;
                        n_state      = S_MOVE;
                    end else begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_DONE;
                        n_state          = S_RESP;
                    end
                end else begin
                    if (i_stat.ptr_gt_pos) begin
                        o_cmd.rd_sel = RD_PTR_DEC;
                        n_state      = S_MOVE;
                    end else begin
                        o_cmd.mem_we     = 1'b1;
                        o_cmd.wr_sel     = WR_POS_VAL;
                        o_cmd.cnt_inc    = 1'b1;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_DONE;
                        n_state          = S_RESP;
                    end
                end
            end
            // Write the fetched neighbor into the pointer slot
            S_MOVE: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wr_sel = WR_PTR_RDATA;
                if (i_stat.op == OP_DELETE) begin
                    o_cmd.ptr_inc = 1'b1;
                end else begin
                    o_cmd.ptr_dec = 1'b1;
                end
                n_state = S_SHIFT;
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESP);

endmodule

### design/indexed_list_insert_delete_top.sv
// Top level of the indexed list block: controller, datapath and checks.
// Keeps an ordered list of up to 1024 signed 32-bit words and serves one transaction at a
// time: read, update, delete or insert at an index, each answered by one result with a
// status, the word read and the new entry count. Delete and insert move the list through
// the entry store one word at a time, a read and then a write per word, so they take
// longer the more entries must move. The next transaction is accepted once the result has
// been taken. The store needs no clearing after reset; words of entries beyond the count
// are never returned.
module indexed_list_insert_delete_top import ilist_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_operation,
    input  logic [W_IDX-1:0]         i_position,
    input  logic signed [W_DATA-1:0] i_new_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic signed [W_DATA-1:0] o_read_value,
    output logic [W_IDX-1:0]         o_entry_count
);

    t_cmd  w_cmd;
    t_stat w_stat;

    ilist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ilist_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    // Count never exceeds the store size
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= W_IDX'(CAPACITY))
        else $error("entry count above capacity");

    // No new transaction is taken while a result is pending
    a_busy_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while result pending");

    // Rejected requests return a zero word
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DONE)) |-> (o_read_value == '0))
        else $error("nonzero word on error result");

    // Count holds while the block is idle
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && !$past(o_in_stall)) |-> $stable(o_entry_count))
        else $error("entry count changed while idle");

endmodule

### sim/tb_indexed_list_insert_delete_top.sv
// Self-checking testbench for the indexed list block.
module tb_indexed_list_insert_delete_top import ilist_pkg::*; ();

    // Expected result of one transaction
    typedef struct packed {
        t_status             status;
        logic [W_DATA-1:0]   read_value;
        logic [W_IDX-1:0]    entry_count;
    } t_result;

    // One row of the directed table; typed rows carry a hand-written result
    typedef struct packed {
        t_op                 op;
        logic [W_IDX-1:0]    pos;
        logic [W_DATA-1:0]   value;
        logic                typed;
        t_result             result;
    } t_row;

    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_PER_PHASE = 185;
    localparam int DRAIN_CYCLES = 2100;   // longer than an insert at the head of a nearly full list

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic [1:0]               i_operation;
    logic [W_IDX-1:0]         i_position;
    logic signed [W_DATA-1:0] i_new_value;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_status;
    logic signed [W_DATA-1:0] o_read_value;
    logic [W_IDX-1:0]         o_entry_count;

    // Predicted list contents and length
    logic [W_DATA-1:0] list_mem [CAPACITY];
    int                list_len;

    t_result pending_results [$];
    int      fail_count;
    int      tx_idle_pct;
    int      rx_idle_pct;

    // Directed table: empty list, extremes, append, out of range, drain to empty
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{OP_READ,   11'd0,    32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd0}},
        '{OP_UPDATE, 11'd0,    32'h0000_1234, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd0}},
        '{OP_DELETE, 11'd0,    32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd0}},
        '{OP_INSERT, 11'd1,    32'h0000_0001, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd0}},
        '{OP_INSERT, 11'd1024, 32'hFFFF_FFFF, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd0}},
        '{OP_INSERT, 11'd0,    32'h7FFF_FFFF, 1'b1, '{ST_DONE,  32'h0000_0000, 11'd1}},
        '{OP_READ,   11'd0,    32'hDEAD_BEEF, 1'b1, '{ST_DONE,  32'h7FFF_FFFF, 11'd1}},
        '{OP_INSERT, 11'd1,    32'h8000_0000, 1'b1, '{ST_DONE,  32'h0000_0000, 11'd2}},
        '{OP_INSERT, 11'd0,    32'hFFFF_FFFF, 1'b1, '{ST_DONE,  32'h0000_0000, 11'd3}},
        '{OP_READ,   11'd2,    32'h0000_0000, 1'b1, '{ST_DONE,  32'h8000_0000, 11'd3}},
        '{OP_INSERT, 11'd1,    32'h0000_0000, 1'b0, '{ST_DONE,  32'h0000_0000, 11'd0}},
        '{OP_READ,   11'd1,    32'hFFFF_FFFF, 1'b0, '{ST_DONE,  32'h0000_0000, 11'd0}},
        '{OP_UPDATE, 11'd3,    32'h5555_5555, 1'b1, '{ST_DONE,  32'h0000_0000, 11'd4}},
        '{OP_READ,   11'd3,    32'h0000_0000, 1'b1, '{ST_DONE,  32'h5555_5555, 11'd4}},
        '{OP_READ,   11'd4,    32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd4}},
        '{OP_UPDATE, 11'd4,    32'h1234_5678, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd4}},
        '{OP_DELETE, 11'd4,    32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd4}},
        '{OP_READ,   11'd1024, 32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd4}},
        '{OP_DELETE, 11'd0,    32'hFFFF_FFFF, 1'b0, '{ST_DONE,  32'h0000_0000, 11'd0}},
        '{OP_READ,   11'd0,    32'h0000_0000, 1'b0, '{ST_DONE,  32'h0000_0000, 11'd0}},
        '{OP_DELETE, 11'd2,    32'h0000_0000, 1'b0, '{ST_DONE,  32'h0000_0000, 11'd0}},
        '{OP_DELETE, 11'd1,    32'h0000_0000, 1'b0, '{ST_DONE,  32'h0000_0000, 11'd0}},
        '{OP_DELETE, 11'd0,    32'h0000_0000, 1'b0, '{ST_DONE,  32'h0000_0000, 11'd0}},
        '{OP_READ,   11'd0,    32'h0000_0000, 1'b1, '{ST_RANGE, 32'h0000_0000, 11'd0}},
        '{OP_INSERT, 11'd0,    32'hAAAA_AAAA, 1'b1, '{ST_DONE,  32'h0000_0000, 11'd1}}
    };

    indexed_list_insert_delete_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_position    (i_position),
        .i_new_value   (i_new_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_read_value  (o_read_value),
        .o_entry_count (o_entry_count)
    );

    // Clock, period 10
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Apply one transaction to the predicted list and return its result
    task automatic predict_request(input t_op op, input logic [W_IDX-1:0] pos,
                                   input logic [W_DATA-1:0] value, output t_result res);
        int p;
        p = int'(pos);
        res = '{ST_DONE, '0, '0};
        if (op == OP_INSERT) begin
            if (p > list_len) begin
                res.status = ST_RANGE;
            end else if (list_len >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // open a gap at p
                for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
                list_mem[p] = value;
                list_len++;
            end
        end else if (p >= list_len) begin
            res.status = ST_RANGE;
        end else if (op == OP_READ) begin
            res.read_value = list_mem[p];
        end else if (op == OP_UPDATE) begin
            list_mem[p] = value;
        end else begin
            // close the gap at p
            list_len--;
            for (int i = p; i < list_len; i++) list_mem[i] = list_mem[i+1];
        end
        res.entry_count = W_IDX'(list_len);
    endtask

    // Drive one transaction, wait for acceptance, queue its expected result
    task automatic send_request(input t_op op, input logic [W_IDX-1:0] pos,
                                input logic [W_DATA-1:0] value, input logic typed,
                                input t_result typed_res);
        t_result predicted;
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_new_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_request(op, pos, value, predicted);
        pending_results.push_back(typed ? typed_res : predicted);
    endtask

    // Random transaction that keeps the list short, mostly in range
    task automatic send_random_request();
        int   pick;
        int   ins_share;
        int   top;
        int   pos;
        t_op  op;
        pick = $urandom_range(99);
        ins_share = (list_len < 8) ? 35 : (list_len > 48) ? 15 : 28;
        if (pick < 25)                  op = OP_READ;
        else if (pick < 45)             op = OP_UPDATE;
        else if (pick < 45 + ins_share) op = OP_INSERT;
        else                            op = OP_DELETE;
        top = (op == OP_INSERT) ? list_len : list_len - 1;
        pick = $urandom_range(99);
        if (pick < 85 && top >= 0) pos = $urandom_range(top, 0);
        else if (pick < 95)        pos = $urandom_range(CAPACITY, top + 1);
        else                       pos = CAPACITY;
        send_request(op, W_IDX'(pos), $urandom, 1'b0, '0);
    endtask

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result status=%0d read=%h count=%0d",
                         $time, o_status, o_read_value, o_entry_count);
                fail_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, o_status);
                    fail_count++;
                end
                if (o_read_value !== exp_res.read_value) begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, exp_res.read_value, o_read_value);
                    fail_count++;
                end
                if (o_entry_count !== exp_res.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, exp_res.entry_count, o_entry_count);
                    fail_count++;
                end
            end
        end
    end

    // Main sequence
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = OP_READ;
        i_position  = '0;
        i_new_value = '0;
        list_len    = 0;
        fail_count  = 0;
        tx_idle_pct = 6;
        rx_idle_pct = 88;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_request(directed_rows[r].op, directed_rows[r].pos, directed_rows[r].value,
                         directed_rows[r].typed, directed_rows[r].result);
        repeat (RANDOM_PER_PHASE) send_random_request();

        // sender mostly idle, receiver mostly ready
        tx_idle_pct = 88;
        rx_idle_pct = 6;
        repeat (RANDOM_PER_PHASE) send_random_request();

        // no idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (RANDOM_PER_PHASE) send_random_request();

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
